[rtl/bfid_pkg.sv]
// Shared types and constants for the box-filter image downscaler.
`default_nettype none
package bfid_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int SUM_W  = 28;
    localparam int CNT_W  = 21;
    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;
    localparam int PIX_W  = 8;
    localparam int LANES  = 4;

    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

    // Configuration register indexes.
    localparam logic [2:0] CFG_SRC_W = 3'd0;
    localparam logic [2:0] CFG_SRC_H = 3'd1;
    localparam logic [2:0] CFG_TGT_W = 3'd2;
    localparam logic [2:0] CFG_TGT_H = 3'd3;

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
        logic [PIX_W-1:0] in_alpha;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_alpha;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             frame_last;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_COL_FIRST,
        OP_ROW_FIRST,
        OP_SUM,
        OP_COL_END,
        OP_ROW_END
    } t_dv_op;

endpackage
`default_nettype wire

[rtl/box_filter_image_downscaler.sv]
// Top level of the box-filter image downscaler: line store, sequencer and shared divider.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_ready      | i_in_data  (t_in_beat)
//  out      | output    | o_out_valid / i_out_ready    | o_out_data (t_out_beat)
//  cfg      | input     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// A pixel with no result is read from the line store and then written back; one that
// moves a column or row boundary, or closes a window, also waits for the divider.
// The 28-step radix-2 divider is shared by the means and bounds.
// After reset or a write to index 0..3 the first bounds are divided before o_in_ready.
// A finished beat waits in the output register; only the next result stalls on it.
`default_nettype none
module box_filter_image_downscaler (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire bfid_pkg::t_in_beat    i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output bfid_pkg::t_out_beat        o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_idx,
    input  wire logic [10:0]           i_cfg_data
);

    localparam int SW = bfid_pkg::SUM_W;
    localparam int CW = bfid_pkg::CNT_W;
    localparam int ZW = bfid_pkg::SIZE_W;
    localparam int PW = bfid_pkg::POS_W;
    localparam int LN = bfid_pkg::LANES;

    // Configuration registers.
    logic [ZW-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic          cfg_hit;

    // Frame position state.
    logic [PW-1:0] r_src_col, r_src_row, r_win_col, r_win_row;
    logic [ZW-1:0] r_col_start, r_col_end, r_row_start, r_row_end;
    logic [ZW-1:0] r_col_first, r_row_first;

    // Sequencer.
    bfid_pkg::t_state r_state, n_state;
    bfid_pkg::t_dv_op r_op, n_op;

    // Line store: four 28-bit channel sums per output column.
    logic [LN*SW-1:0] mem [bfid_pkg::MAX_WIDTH];
    logic [LN*SW-1:0] r_rd;
    bfid_pkg::t_in_beat r_px;

    // Divider lanes.
    logic [SW-1:0] r_dq [LN];
    logic [CW-1:0] r_dr [LN];
    logic [CW-1:0] r_dsr;
    logic [4:0]    r_dv_cnt;
    logic [SW-1:0] n_dq [LN];
    logic [CW-1:0] n_dr [LN];

    // Pending boundary divide after a result.
    logic              r_bnd_go;
    bfid_pkg::t_dv_op  r_bnd_op;
    logic [SW-1:0]     r_bnd_dvd;
    logic [ZW-1:0]     r_bnd_dsr;

    // Result fields held while the means are divided.
    logic [PW-1:0] r_res_col, r_res_row;
    logic          r_res_last;

    // Output register.
    logic                r_out_valid;
    bfid_pkg::t_out_beat r_out;

    // Effective sizes.
    logic [ZW-1:0] eff_sw, eff_sh, eff_tw, eff_th;

    // Step logic signals.
    logic            in_acc, out_free;
    logic            ld_first, res_hit;
    logic [LN*SW-1:0] new_sums;
    logic [CW-1:0]   win_count;
    logic [2*ZW-1:0] cnt_prod, bnd_prod;
    logic [ZW-1:0]   sc1, wc1, sr1, wr1, mul_a, mul_b, bnd_dsr;
    logic            col_adv, col_wrap, row_adv, row_wrap;
    logic            pend_col, pend_row;

    // Divider control.
    logic                 dv_load, out_load;
    logic [LN-1:0][SW-1:0] dv_dvd;
    logic [CW-1:0]        dv_dsr;

    assign cfg_hit  = i_cfg_we && !i_cfg_idx[2];
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Clamp the sizes: sources to 1..max, targets to 1..source.
    always_comb begin
        eff_sw = (r_src_w == '0) ? ZW'(1) : ((r_src_w > bfid_pkg::MAX_W_SZ) ?
                 bfid_pkg::MAX_W_SZ : r_src_w);
        eff_sh = (r_src_h == '0) ? ZW'(1) : ((r_src_h > bfid_pkg::MAX_H_SZ) ?
                 bfid_pkg::MAX_H_SZ : r_src_h);
        eff_tw = (r_tgt_w == '0) ? ZW'(1) : ((r_tgt_w > eff_sw) ? eff_sw : r_tgt_w);
        eff_th = (r_tgt_h == '0) ? ZW'(1) : ((r_tgt_h > eff_sh) ? eff_sh : r_tgt_h);
    end

    // Accumulate the pixel and work out the position update.
    always_comb begin
        ld_first = ({1'b0, r_src_row} == r_row_start) && ({1'b0, r_src_col} == r_col_start);
        new_sums[4*SW-1:3*SW] = (ld_first ? '0 : r_rd[4*SW-1:3*SW]) + SW'(r_px.in_red);
        new_sums[3*SW-1:2*SW] = (ld_first ? '0 : r_rd[3*SW-1:2*SW]) + SW'(r_px.in_green);
        new_sums[2*SW-1:SW]   = (ld_first ? '0 : r_rd[2*SW-1:SW])   + SW'(r_px.in_blue);
        new_sums[SW-1:0]      = (ld_first ? '0 : r_rd[SW-1:0])      + SW'(r_px.in_alpha);

        sc1     = ZW'(r_src_col) + ZW'(1);
        sr1     = ZW'(r_src_row) + ZW'(1);
        res_hit = (sc1 == r_col_end) && (sr1 == r_row_end);
        cnt_prod = (r_col_end - r_col_start) * (r_row_end - r_row_start);
        win_count = (cnt_prod[CW-1:0] == '0) ? CW'(1) : cnt_prod[CW-1:0];

        col_adv  = sc1 >= r_col_end;
        wc1      = col_adv ? ZW'(r_win_col) + ZW'(1) : ZW'(r_win_col);
        col_wrap = (sc1 >= eff_sw) || (wc1 >= eff_tw);
        row_adv  = sr1 >= r_row_end;
        wr1      = row_adv ? ZW'(r_win_row) + ZW'(1) : ZW'(r_win_row);
        row_wrap = (sr1 >= eff_sh) || (wr1 >= eff_th);
        pend_col = col_adv && !col_wrap;
        pend_row = col_wrap && row_adv && !row_wrap;

        // One multiplier serves the next column or row boundary.
        mul_a    = pend_col ? wc1 + ZW'(1) : wr1 + ZW'(1);
        mul_b    = pend_col ? eff_sw : eff_sh;
        bnd_dsr  = pend_col ? eff_tw : eff_th;
        bnd_prod = mul_a * mul_b;
    end

    // One radix-2 restoring step in each lane.
    always_comb begin
        logic [CW:0] trial;
        logic        ge;
        for (int k = 0; k < LN; k++) begin
            trial   = {r_dr[k], r_dq[k][SW-1]};
            ge      = trial >= {1'b0, r_dsr};
            n_dr[k] = ge ? CW'(trial - {1'b0, r_dsr}) : trial[CW-1:0];
            n_dq[k] = {r_dq[k][SW-2:0], ge};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfid_pkg::S_INIT: n_state = bfid_pkg::S_DIV;
            bfid_pkg::S_IDLE: if (in_acc) n_state = bfid_pkg::S_READ;
            bfid_pkg::S_READ: begin
                if (res_hit || pend_col || pend_row) n_state = bfid_pkg::S_DIV;
                else                                 n_state = bfid_pkg::S_IDLE;
            end
            bfid_pkg::S_DIV: if (r_dv_cnt == '0) n_state = bfid_pkg::S_FIN;
            bfid_pkg::S_FIN: begin
                case (r_op)
                    bfid_pkg::OP_COL_FIRST: n_state = bfid_pkg::S_DIV;
                    bfid_pkg::OP_SUM: begin
                        if (out_free) n_state = r_bnd_go ? bfid_pkg::S_DIV : bfid_pkg::S_IDLE;
                    end
                    default: n_state = bfid_pkg::S_IDLE;
                endcase
            end
            default: n_state = bfid_pkg::S_INIT;
        endcase
    end

    // Sequencer outputs: divider loads and output register load.
    always_comb begin
        dv_load  = 1'b0;
        out_load = 1'b0;
        n_op     = r_op;
        dv_dsr   = CW'(eff_tw);
        for (int k = 0; k < LN; k++) dv_dvd[k] = SW'(eff_sw);
        unique case (r_state)
            bfid_pkg::S_INIT: begin
                dv_load = 1'b1;
                n_op    = bfid_pkg::OP_COL_FIRST;
            end
            bfid_pkg::S_READ: begin
                if (res_hit) begin
                    dv_load = 1'b1;
                    n_op    = bfid_pkg::OP_SUM;
                    dv_dsr  = win_count;
                    for (int k = 0; k < LN; k++) dv_dvd[k] = new_sums[(LN-1-k)*SW +: SW];
                end else if (pend_col || pend_row) begin
                    dv_load = 1'b1;
                    n_op    = pend_col ? bfid_pkg::OP_COL_END : bfid_pkg::OP_ROW_END;
                    dv_dsr  = CW'(bnd_dsr);
                    for (int k = 0; k < LN; k++) dv_dvd[k] = SW'(bnd_prod);
                end
            end
            bfid_pkg::S_FIN: begin
                if (r_op == bfid_pkg::OP_COL_FIRST) begin
                    dv_load = 1'b1;
                    n_op    = bfid_pkg::OP_ROW_FIRST;
                    dv_dsr  = CW'(eff_th);
                    for (int k = 0; k < LN; k++) dv_dvd[k] = SW'(eff_sh);
                end else if (r_op == bfid_pkg::OP_SUM && out_free) begin
                    out_load = 1'b1;
                    dv_load  = r_bnd_go;
                    n_op     = r_bnd_op;
                    dv_dsr   = CW'(r_bnd_dsr);
                    for (int k = 0; k < LN; k++) dv_dvd[k] = r_bnd_dvd;
                end
            end
            default: ;
        endcase
    end

    // Line store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (in_acc) r_rd <= mem[r_win_col];
        if (r_state == bfid_pkg::S_READ) mem[r_win_col] <= new_sums;
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) r_px <= i_in_data;
        if (dv_load) begin
            r_dsr <= dv_dsr;
            for (int k = 0; k < LN; k++) begin
                r_dq[k] <= dv_dvd[k];
                r_dr[k] <= '0;
            end
        end else if (r_state == bfid_pkg::S_DIV) begin
            for (int k = 0; k < LN; k++) begin
                r_dq[k] <= n_dq[k];
                r_dr[k] <= n_dr[k];
            end
        end
        if (r_state == bfid_pkg::S_READ) begin
            r_bnd_op   <= pend_col ? bfid_pkg::OP_COL_END : bfid_pkg::OP_ROW_END;
            r_bnd_dvd  <= SW'(bnd_prod);
            r_bnd_dsr  <= bnd_dsr;
            r_res_col  <= r_win_col;
            r_res_row  <= r_win_row;
            r_res_last <= (ZW'(r_win_col) + ZW'(1) == eff_tw) &&
                          (ZW'(r_win_row) + ZW'(1) == eff_th);
        end
        if (out_load) begin
            r_out.out_red    <= r_dq[0][7:0];
            r_out.out_green  <= r_dq[1][7:0];
            r_out.out_blue   <= r_dq[2][7:0];
            r_out.out_alpha  <= r_dq[3][7:0];
            r_out.out_col    <= r_res_col;
            r_out.out_row    <= r_res_row;
            r_out.frame_last <= r_res_last;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfid_pkg::S_INIT;
            r_op        <= bfid_pkg::OP_COL_FIRST;
            r_src_w     <= bfid_pkg::MAX_W_SZ;
            r_src_h     <= bfid_pkg::MAX_H_SZ;
            r_tgt_w     <= ZW'(128);
            r_tgt_h     <= ZW'(128);
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_win_col   <= '0;
            r_win_row   <= '0;
            r_col_start <= '0;
            r_row_start <= '0;
            r_col_end   <= '0;
            r_row_end   <= '0;
            r_col_first <= '0;
            r_row_first <= '0;
            r_dv_cnt    <= '0;
            r_bnd_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_op <= n_op;
            if (dv_load)                         r_dv_cnt <= 5'(SW - 1);
            else if (r_state == bfid_pkg::S_DIV) r_dv_cnt <= r_dv_cnt - 5'd1;

            if (out_load)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;

            // Register writes restart the frame and recompute the first bounds.
            if (cfg_hit) begin
                r_state <= bfid_pkg::S_INIT;
                case (i_cfg_idx)
                    bfid_pkg::CFG_SRC_W: r_src_w <= i_cfg_data;
                    bfid_pkg::CFG_SRC_H: r_src_h <= i_cfg_data;
                    bfid_pkg::CFG_TGT_W: r_tgt_w <= i_cfg_data;
                    default:             r_tgt_h <= i_cfg_data;
                endcase
                r_src_col   <= '0;
                r_src_row   <= '0;
                r_win_col   <= '0;
                r_win_row   <= '0;
                r_col_start <= '0;
                r_row_start <= '0;
            end else begin
                r_state <= n_state;
            end

            // Bounds coming out of the divider.
            if (r_state == bfid_pkg::S_FIN) begin
                case (r_op)
                    bfid_pkg::OP_COL_FIRST: begin
                        r_col_first <= r_dq[0][ZW-1:0];
                        r_col_end   <= r_dq[0][ZW-1:0];
                    end
                    bfid_pkg::OP_ROW_FIRST: begin
                        r_row_first <= r_dq[0][ZW-1:0];
                        r_row_end   <= r_dq[0][ZW-1:0];
                    end
                    bfid_pkg::OP_COL_END: r_col_end <= r_dq[0][ZW-1:0];
                    bfid_pkg::OP_ROW_END: r_row_end <= r_dq[0][ZW-1:0];
                    default: ;
                endcase
            end

            // Position update once the sum is written back.
            if (r_state == bfid_pkg::S_READ && !cfg_hit) begin
                r_bnd_go <= res_hit && (pend_col || pend_row);
                if (!col_wrap) begin
                    r_src_col <= sc1[PW-1:0];
                    if (col_adv) begin
                        r_win_col   <= wc1[PW-1:0];
                        r_col_start <= r_col_end;
                    end
                end else begin
                    r_src_col   <= '0;
                    r_win_col   <= '0;
                    r_col_start <= '0;
                    r_col_end   <= r_col_first;
                    if (!row_wrap) begin
                        r_src_row <= sr1[PW-1:0];
                        if (row_adv) begin
                            r_win_row   <= wr1[PW-1:0];
                            r_row_start <= r_row_end;
                        end
                    end else begin
                        r_src_row   <= '0;
                        r_win_row   <= '0;
                        r_row_start <= '0;
                        r_row_end   <= r_row_first;
                    end
                end
            end
        end
    end

    assign o_in_ready  = (r_state == bfid_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

[rtl/bfid_checker.sv]
// Port-level checker for the box-filter image downscaler, with its bind.
`default_nettype none
module bfid_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire bfid_pkg::t_out_beat o_out_data,
    input wire logic                i_cfg_we,
    input wire logic [2:0]          i_cfg_idx
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // One pixel is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a pixel is in flight");

    // A result needs at least the read and write-back cycles.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared right after an input beat");

    // A register write restarts the frame and recomputes the bounds.
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && !i_cfg_idx[2] |=> !o_in_ready)
        else $error("input ready right after a register write");

endmodule

bind box_filter_image_downscaler bfid_checker u_bfid_checker (.*);
`default_nettype wire
